// File: rtl/ufr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_pkg
// Types and constants shared by the oversampled UART frame receiver.
// ----------------------------------------------------------------------------
package ufr_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int TIMER_W    = 8;
	localparam int VOTES_W    = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MASK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_VOTE_THR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 2'd3;

	// configuration reset values
	localparam logic [7:0] SAMPLE_MASK_RST  = 8'd28;
	localparam logic [3:0] HIGH_VOTE_RST    = 4'd2;
	localparam logic [7:0] GAP_TIMEOUT_RST  = 8'd40;
	localparam logic [7:0] IDLE_TIMEOUT_RST = 8'd255;

	// receiver phases
	localparam logic [1:0] PH_WAIT  = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;

	localparam logic [VOTES_W-1:0] VOTES_MAX = 4'hF;

	typedef struct packed {
		logic [7:0]         sample_mask;
		logic [3:0]         high_vote_threshold;
		logic [TIMER_W-1:0] gap_timeout;
		logic [TIMER_W-1:0] idle_timeout;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic [3:0] byte_index;
		logic       frame_done;
		logic [4:0] frame_length;
		logic       frame_end_reason;
	} res_t;

endpackage

// File: rtl/ufr_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module ufr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ufr_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ufr_pkg::cfg_t                 cfg
);
	import ufr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_mask         <= SAMPLE_MASK_RST;
			cfg_q.high_vote_threshold <= HIGH_VOTE_RST;
			cfg_q.gap_timeout         <= GAP_TIMEOUT_RST;
			cfg_q.idle_timeout        <= IDLE_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_MASK:   cfg_q.sample_mask         <= cfg_wdata;
				CFG_HIGH_VOTE_THR: cfg_q.high_vote_threshold <= cfg_wdata[3:0];
				CFG_GAP_TIMEOUT:   cfg_q.gap_timeout         <= cfg_wdata;
				CFG_IDLE_TIMEOUT:  cfg_q.idle_timeout        <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/ufr_rx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_rx_core
// Receiver state and its single-pass update for one line sample.
// ----------------------------------------------------------------------------
module ufr_rx_core #(
	parameter int SAMPLES_PER_BIT = 8,
	parameter int FRAME_BYTES     = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          level,
	input  ufr_pkg::cfg_t cfg,
	output logic          has_result,
	output ufr_pkg::res_t result
);
	import ufr_pkg::*;

	localparam int SPB = SAMPLES_PER_BIT;
	localparam int CW  = $clog2(FRAME_BYTES + 1);
	localparam logic [SPB-1:0] SLOT_TOP  = SPB'(1) << (SPB - 1);
	localparam logic [SPB-1:0] SLOT_HALF = SLOT_TOP >> 1;
	localparam logic [CW-1:0]  COUNT_FULL = CW'(FRAME_BYTES);

	logic [1:0]         phase_q, phase_d;
	logic [SPB-1:0]     slot_q, slot_d;
	logic [VOTES_W-1:0] votes_q, votes_d, votes_v;
	logic [7:0]         bit_q, bit_d;
	logic [7:0]         shift_q, shift_d;
	logic [CW-1:0]      count_q, count_d, count_inc, length_src;
	logic [TIMER_W-1:0] timer_q, timer_d, timer_v;

	logic [SPB+7:0]     mask_ext;
	logic [SPB-1:0]     mask_slot;
	logic [CW+4:0]      idx_ext, len_ext;
	logic               got_byte, done, reason;

	assign mask_ext  = {{SPB{1'b0}}, cfg.sample_mask};
	assign mask_slot = mask_ext[SPB-1:0];
	assign count_inc = count_q + 1'b1;

	always_comb begin
		phase_d  = phase_q;
		slot_d   = slot_q;
		votes_d  = votes_q;
		votes_v  = votes_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		count_d  = count_q;
		timer_d  = timer_q;
		got_byte = 1'b0;
		done     = 1'b0;
		reason   = 1'b0;

		if (phase_q != PH_START && phase_q != PH_DATA) begin
			if (!level) begin
				phase_d = PH_START;
				votes_d = '0;
				slot_d  = SLOT_HALF;
			end
		end else begin
			if (level && (slot_q & mask_slot) != '0 && votes_q != VOTES_MAX)
				votes_v = votes_q + 1'b1;
			votes_d = votes_v;
			slot_d  = slot_q >> 1;
			if ((slot_q >> 1) == '0) begin
				// bit period over
				slot_d  = SLOT_TOP;
				votes_d = '0;
				if (phase_q == PH_START) begin
					if (votes_v < cfg.high_vote_threshold) begin
						phase_d = PH_DATA;
						shift_d = '0;
						bit_d   = 8'd1;
						timer_d = cfg.gap_timeout;
					end else begin
						phase_d = PH_WAIT;
					end
				end else if (bit_q != '0) begin
					if (votes_v >= cfg.high_vote_threshold)
						shift_d = shift_q | bit_q;
					bit_d = bit_q << 1;
				end else begin
					// stop bit: emit the word, stop level is not checked
					phase_d  = PH_WAIT;
					got_byte = 1'b1;
					count_d  = count_inc;
					if (count_inc == COUNT_FULL)
						done = 1'b1;
				end
			end
		end

		timer_v = timer_d;
		if (timer_v != '0)
			timer_v = timer_v - 1'b1;
		timer_d = timer_v;
		if (!done && timer_v == '0) begin
			done   = 1'b1;
			reason = 1'b1;
		end

		if (done) begin
			phase_d = PH_WAIT;
			slot_d  = SLOT_TOP;
			votes_d = '0;
			bit_d   = 8'd1;
			shift_d = '0;
			count_d = '0;
			timer_d = cfg.idle_timeout;
		end
	end

	assign length_src = got_byte ? count_inc : count_q;
	assign idx_ext    = {5'b0, count_q};
	assign len_ext    = {5'b0, length_src};

	assign has_result              = got_byte | done;
	assign result.data_byte        = got_byte ? shift_q : 8'd0;
	assign result.byte_valid       = got_byte;
	assign result.byte_index       = got_byte ? idx_ext[3:0] : 4'd0;
	assign result.frame_done       = done;
	assign result.frame_length     = done ? len_ext[4:0] : 5'd0;
	assign result.frame_end_reason = done & reason;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			slot_q  <= SLOT_TOP;
			votes_q <= '0;
			bit_q   <= 8'd1;
			shift_q <= '0;
			count_q <= '0;
			timer_q <= IDLE_TIMEOUT_RST;
		end else if (step) begin
			phase_q <= phase_d;
			slot_q  <= slot_d;
			votes_q <= votes_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			count_q <= count_d;
			timer_q <= timer_d;
		end
	end

endmodule

// File: rtl/ufr_result_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufr_result_reg
// Output register holding one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module ufr_result_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  ufr_pkg::res_t load_data,
	input  logic          out_ready,
	output logic          out_valid,
	output logic          free,
	output ufr_pkg::res_t data
);
	import ufr_pkg::*;

	logic valid_q;
	res_t data_q;

	assign free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= load_data;
	end

	assign out_valid = valid_q;
	assign data      = data_q;

endmodule

// File: rtl/oversampled_uart_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oversampled_uart_frame_receiver_top
// 8N1 UART receiver on oversampled line ticks with threshold voting and
// frame end detection by buffer fill or silence timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_level) carries one line sample per
//   word. Output channel (out_valid/out_ready) carries one result word per
//   completed byte and/or ended frame; samples that finish nothing give none.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata);
//   write it only while no sample is in flight.
// Sample path: an accepted sample is held in the sample register; when it
//   advances it updates the receiver state and its result goes to the output.
// Throughput: one sample per cycle when not stalled; the state update is a
//   single pass of logic between the sample and receiver/result registers.
// Reset: configuration returns to its defaults, the receiver waits for a
//   start bit and the silence timer is loaded with the idle timeout.
// Stall: while the result register is held, a sample that would produce a
//   result waits in the sample register and in_ready drops; samples that
//   produce nothing keep flowing.
// ----------------------------------------------------------------------------
module oversampled_uart_frame_receiver_top #(
	parameter int SAMPLES_PER_BIT = 8,
	parameter int FRAME_BYTES     = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           rx_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     data_byte,
	output logic                           byte_valid,
	output logic [3:0]                     byte_index,
	output logic                           frame_done,
	output logic [4:0]                     frame_length,
	output logic                           frame_end_reason,
	input  logic                           cfg_we,
	input  logic [ufr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ufr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ufr_pkg::*;

	cfg_t cfg;
	res_t core_res, out_res;
	logic valid_s1, rx_s1;
	logic has_result, out_free, advance, load;

	ufr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// advance the held sample unless it has a result and the output is blocked
	assign advance  = valid_s1 && (!has_result || out_free);
	assign load     = advance && has_result;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			rx_s1 <= rx_level;
	end

	ufr_rx_core #(
		.SAMPLES_PER_BIT (SAMPLES_PER_BIT),
		.FRAME_BYTES     (FRAME_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.level      (rx_s1),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (core_res)
	);

	ufr_result_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_data (core_res),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.free      (out_free),
		.data      (out_res)
	);

	assign data_byte        = out_res.data_byte;
	assign byte_valid       = out_res.byte_valid;
	assign byte_index       = out_res.byte_index;
	assign frame_done       = out_res.frame_done;
	assign frame_length     = out_res.frame_length;
	assign frame_end_reason = out_res.frame_end_reason;

`ifndef ASSERT_OFF
	a_result_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_valid || frame_done))
		else $error("result word carries neither a byte nor a frame end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid || out_ready))
		else $error("result register loaded while still held");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done && !frame_end_reason) |->
			(byte_valid && frame_length == 5'(FRAME_BYTES)))
		else $error("buffer full frame end with wrong length");

	a_stalled_sample_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(rx_s1)))
		else $error("blocked sample lost from the sample register");
`endif

endmodule
